@@ design/dual_tilt_angle_averager_macros.svh @@
// Assertion macros for the verification file of the tilt averager.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DUAL_TILT_ANGLE_AVERAGER_MACROS_SVH
`define DUAL_TILT_ANGLE_AVERAGER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTAA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTAA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dtaa_pkg.sv @@
package dtaa_pkg;

  // Input sample and angle widths.
  localparam int IN_W  = 16;
  localparam int ANG_W = 9;

  // Averaging window and the running sum that covers it.
  localparam int WINDOW = 8;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = ANG_W + $clog2(WINDOW);

  // Division by the window as a multiply by a rounded-up reciprocal.
  localparam int DIV_K     = SUM_W + 8;
  localparam int DIV_RECIP = ((1 << DIV_K) + WINDOW - 1) / WINDOW;

  // CORDIC sizing: samples are prescaled by 2^14, the angle accumulator
  // holds degrees with 16 fraction bits.
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int PRESCALE_SH  = 14;
  localparam int FRAC_BITS    = 16;
  localparam int XY_W         = 34;
  localparam int ACC_W        = 26;

  // Angles that come out directly for the special operand cases.
  localparam logic signed [ANG_W-1:0] ANG_ZERO = ANG_W'(0);
  localparam logic signed [ANG_W-1:0] ANG_P45  = ANG_W'(45);
  localparam logic signed [ANG_W-1:0] ANG_M45  = ANG_W'(-45);
  localparam logic signed [ANG_W-1:0] ANG_P90  = ANG_W'(90);
  localparam logic signed [ANG_W-1:0] ANG_M90  = ANG_W'(-90);
  localparam logic signed [ANG_W-1:0] ANG_P135 = ANG_W'(135);
  localparam logic signed [ANG_W-1:0] ANG_M135 = ANG_W'(-135);
  localparam logic signed [ANG_W-1:0] ANG_P180 = ANG_W'(180);
  localparam logic signed [ANG_W-1:0] ANG_M180 = ANG_W'(-180);

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic step;
    logic angle;
    logic ring;
    logic div;
  } dtaa_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic last_step;
  } dtaa_status_t;

  // atan(2^-i) in degrees with 16 fraction bits.
  function automatic logic signed [ACC_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic signed [ACC_W-1:0] val;
    unique case (idx)
      5'd0:    val = ACC_W'(2949120);
      5'd1:    val = ACC_W'(1740967);
      5'd2:    val = ACC_W'(919879);
      5'd3:    val = ACC_W'(466945);
      5'd4:    val = ACC_W'(234379);
      5'd5:    val = ACC_W'(117304);
      5'd6:    val = ACC_W'(58666);
      5'd7:    val = ACC_W'(29335);
      5'd8:    val = ACC_W'(14668);
      5'd9:    val = ACC_W'(7334);
      5'd10:   val = ACC_W'(3667);
      5'd11:   val = ACC_W'(1833);
      5'd12:   val = ACC_W'(917);
      5'd13:   val = ACC_W'(458);
      5'd14:   val = ACC_W'(229);
      5'd15:   val = ACC_W'(115);
      5'd16:   val = ACC_W'(57);
      5'd17:   val = ACC_W'(29);
      5'd18:   val = ACC_W'(14);
      5'd19:   val = ACC_W'(7);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ design/dtaa_cordic_lane.sv @@
module dtaa_cordic_lane import dtaa_pkg::*; (
  input  logic                     clk,
  input  logic signed [IN_W-1:0]   num,
  input  logic signed [IN_W-1:0]   den,
  input  logic                     load,
  input  logic                     step,
  input  logic [STEP_W-1:0]        step_idx,
  output logic signed [ANG_W-1:0]  deg
);

  localparam int DEG_W = ACC_W - FRAC_BITS + 1;
  localparam logic signed [ACC_W-1:0] ACC_P90 = ACC_W'(90 * 65536);
  localparam logic signed [DEG_W-1:0] DEG_MAX = DEG_W'(180);
  localparam logic signed [DEG_W-1:0] DEG_MIN = DEG_W'(-180);

  logic signed [IN_W:0]        num_w;
  logic signed [IN_W:0]        den_w;
  logic        [IN_W:0]        num_abs;
  logic        [IN_W:0]        den_abs;
  logic signed [IN_W:0]        x_init;
  logic signed [IN_W:0]        y_init;
  logic signed [ACC_W-1:0]     acc_init;
  logic                        fix_hit;
  logic signed [ANG_W-1:0]     fix_val;

  logic signed [XY_W-1:0]      x;
  logic signed [XY_W-1:0]      y;
  logic signed [ACC_W-1:0]     acc;
  logic                        fixed;
  logic signed [ANG_W-1:0]     fix_ang;

  logic signed [XY_W-1:0]      xs;
  logic signed [XY_W-1:0]      ys;
  logic [ACC_W-1:0]            acc_mag;
  logic [ACC_W-FRAC_BITS-1:0]  whole;
  logic signed [DEG_W-1:0]     deg_w;

  assign num_w   = (IN_W+1)'(num);
  assign den_w   = (IN_W+1)'(den);
  assign num_abs = num_w[IN_W] ? (IN_W+1)'(-num_w) : (IN_W+1)'(num_w);
  assign den_abs = den_w[IN_W] ? (IN_W+1)'(-den_w) : (IN_W+1)'(den_w);

  // Special operands give the angle at once; a left half plane vector is
  // turned by a quarter turn so that the iterations start with x positive.
  always_comb begin
    fix_hit  = 1'b1;
    fix_val  = ANG_ZERO;
    x_init   = den_w;
    y_init   = num_w;
    acc_init = '0;
    priority if (num_w == '0) begin
      fix_val = den_w[IN_W] ? ANG_P180 : ANG_ZERO;
    end else if (den_w == '0) begin
      fix_val = num_w[IN_W] ? ANG_M90 : ANG_P90;
    end else if (num_abs == den_abs) begin
      if (!den_w[IN_W]) begin
        fix_val = num_w[IN_W] ? ANG_M45 : ANG_P45;
      end else begin
        fix_val = num_w[IN_W] ? ANG_M135 : ANG_P135;
      end
    end else begin
      fix_hit = 1'b0;
    end
    if (den_w[IN_W]) begin
      if (!num_w[IN_W]) begin
        x_init   = num_w;
        y_init   = -den_w;
        acc_init = ACC_P90;
      end else begin
        x_init   = -num_w;
        y_init   = den_w;
        acc_init = -ACC_P90;
      end
    end
  end

  assign xs = x >>> step_idx;
  assign ys = y >>> step_idx;

  // One vectoring iteration per step; y is driven toward zero.
  always_ff @(posedge clk) begin
    if (load) begin
      x       <= XY_W'(x_init) <<< PRESCALE_SH;
      y       <= XY_W'(y_init) <<< PRESCALE_SH;
      acc     <= acc_init;
      fixed   <= fix_hit;
      fix_ang <= fix_val;
    end else if (step) begin
      if (!y[XY_W-1] && (y != '0)) begin
        x   <= x + ys;
        y   <= y - xs;
        acc <= acc + atan_entry(step_idx);
      end else begin
        x   <= x - ys;
        y   <= y + xs;
        acc <= acc - atan_entry(step_idx);
      end
    end
  end

  // Whole degrees truncated toward zero, then clamped to a half turn.
  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign whole   = acc_mag[ACC_W-1:FRAC_BITS];
  assign deg_w   = acc[ACC_W-1] ? -$signed({1'b0, whole}) : $signed({1'b0, whole});

  always_comb begin
    priority if (fixed) begin
      deg = fix_ang;
    end else if (deg_w > DEG_MAX) begin
      deg = ANG_P180;
    end else if (deg_w < DEG_MIN) begin
      deg = ANG_M180;
    end else begin
      deg = ANG_W'(deg_w);
    end
  end

endmodule

@@ design/dtaa_datapath.sv @@
module dtaa_datapath import dtaa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  dtaa_cmd_t                cmd,
  output dtaa_status_t             status,
  input  logic signed [IN_W-1:0]   accel_x,
  input  logic signed [IN_W-1:0]   accel_y,
  input  logic signed [IN_W-1:0]   accel_z,
  output logic signed [ANG_W-1:0]  roll_degrees,
  output logic signed [ANG_W-1:0]  pitch_degrees
);

  localparam int PROD_W = SUM_W + DIV_K + 1;

  logic [STEP_W-1:0]        step_cnt;
  logic signed [ANG_W-1:0]  roll_deg;
  logic signed [ANG_W-1:0]  pitch_deg;

  logic signed [ANG_W-1:0]  roll_ring [WINDOW];
  logic signed [ANG_W-1:0]  pitch_ring [WINDOW];
  logic [SLOT_W-1:0]        slot;
  logic                     primed;
  logic                     wrapped;

  logic signed [ANG_W-1:0]  roll_ang;
  logic signed [ANG_W-1:0]  pitch_ang;
  logic signed [ANG_W-1:0]  roll_old;
  logic signed [ANG_W-1:0]  pitch_old;
  logic signed [ANG_W-1:0]  roll_first;
  logic signed [ANG_W-1:0]  pitch_first;
  logic signed [ANG_W-1:0]  roll_leave;
  logic signed [ANG_W-1:0]  pitch_leave;
  logic signed [SUM_W-1:0]  roll_sum;
  logic signed [SUM_W-1:0]  pitch_sum;

  // Sum over the window divided by its length, truncated toward zero.
  function automatic logic signed [ANG_W-1:0] window_avg(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  q;
    mag  = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    prod = PROD_W'(mag) * PROD_W'(DIV_RECIP);
    q    = prod[DIV_K +: SUM_W];
    return s[SUM_W-1] ? ANG_W'(-q) : ANG_W'(q);
  endfunction

  dtaa_cordic_lane u_roll (
    .clk      (clk),
    .num      (accel_y),
    .den      (accel_z),
    .load     (cmd.load),
    .step     (cmd.step),
    .step_idx (step_cnt),
    .deg      (roll_deg)
  );

  dtaa_cordic_lane u_pitch (
    .clk      (clk),
    .num      (accel_x),
    .den      (accel_z),
    .load     (cmd.load),
    .step     (cmd.step),
    .step_idx (step_cnt),
    .deg      (pitch_deg)
  );

  // Iteration counter shared by both lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.load) begin
      step_cnt <= '0;
    end else if (cmd.step) begin
      step_cnt <= step_cnt + 1'b1;
    end
  end

  assign status.last_step = (step_cnt == STEP_W'(CORDIC_STEPS - 1));

  // Ring position and fill state. Until the ring wraps once, the angle that
  // leaves the window is the first angle, not the slot's content.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      primed  <= 1'b0;
      wrapped <= 1'b0;
    end else if (cmd.ring) begin
      primed <= 1'b1;
      if (slot == SLOT_W'(WINDOW - 1)) begin
        slot    <= '0;
        wrapped <= 1'b1;
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

  // Ring storage: one registered read and one write per item.
  always_ff @(posedge clk) begin
    if (cmd.angle) begin
      roll_old  <= roll_ring[slot];
      pitch_old <= pitch_ring[slot];
    end
    if (cmd.ring) begin
      roll_ring[slot]  <= roll_ang;
      pitch_ring[slot] <= pitch_ang;
    end
  end

  assign roll_leave  = wrapped ? roll_old : roll_first;
  assign pitch_leave = wrapped ? pitch_old : pitch_first;

  // Angle capture, running window sums and the averaged beat.
  always_ff @(posedge clk) begin
    if (cmd.angle) begin
      roll_ang  <= roll_deg;
      pitch_ang <= pitch_deg;
    end
    if (cmd.ring) begin
      if (!primed) begin
        roll_first  <= roll_ang;
        pitch_first <= pitch_ang;
        roll_sum    <= SUM_W'(roll_ang * WINDOW);
        pitch_sum   <= SUM_W'(pitch_ang * WINDOW);
      end else begin
        roll_sum  <= roll_sum - SUM_W'(roll_leave) + SUM_W'(roll_ang);
        pitch_sum <= pitch_sum - SUM_W'(pitch_leave) + SUM_W'(pitch_ang);
      end
    end
    if (cmd.div) begin
      roll_degrees  <= window_avg(roll_sum);
      pitch_degrees <= window_avg(pitch_sum);
    end
  end

endmodule

@@ design/dtaa_ctrl.sv @@
module dtaa_ctrl import dtaa_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  dtaa_status_t  status,
  output dtaa_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITER,
    ST_ANGLE,
    ST_RING,
    ST_DIV
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Commands follow the state; the result register is loaded only when free.
  always_comb begin
    cmd.load  = (state == ST_IDLE) && in_valid;
    cmd.step  = (state == ST_ITER);
    cmd.angle = (state == ST_ANGLE);
    cmd.ring  = (state == ST_RING);
    cmd.div   = (state == ST_DIV) && out_free;
  end

  // Sequencer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_ITER;
          end
        end
        ST_ITER: begin
          if (status.last_step) begin
            state <= ST_ANGLE;
          end
        end
        ST_ANGLE: begin
          state <= ST_RING;
        end
        ST_RING: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmd.div) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/dual_tilt_angle_averager.sv @@
// Each sample runs the 20 CORDIC iterations that both angle lanes do side
// by side, one iteration per cycle, then the angle, ring and divide states.
// No new sample is taken until the result is in the output register.
// A finished result waits in the output register while the next sample runs.
// Reset (synchronous, active high) empties the window; the first sample then
// fills the whole window with its own angles.
module dual_tilt_angle_averager import dtaa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [IN_W-1:0]   accel_x,
  input  logic signed [IN_W-1:0]   accel_y,
  input  logic signed [IN_W-1:0]   accel_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ANG_W-1:0]  roll_degrees,
  output logic signed [ANG_W-1:0]  pitch_degrees
);

  dtaa_cmd_t    cmd;
  dtaa_status_t status;

  dtaa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dtaa_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .accel_x       (accel_x),
    .accel_y       (accel_y),
    .accel_z       (accel_z),
    .roll_degrees  (roll_degrees),
    .pitch_degrees (pitch_degrees)
  );

endmodule

@@ design/dtaa_checker.sv @@
`include "dual_tilt_angle_averager_macros.svh"

module dtaa_checker import dtaa_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [ANG_W-1:0]  roll_degrees,
  input logic signed [ANG_W-1:0]  pitch_degrees
);

  logic               in_take;
  logic               out_held;
  logic [2*ANG_W-1:0] out_beat;
  logic               in_range;

  assign in_take  = in_valid && !in_stall;
  assign out_held = out_valid && out_stall;
  assign out_beat = {roll_degrees, pitch_degrees};
  assign in_range = (roll_degrees >= -9'sd180) && (roll_degrees <= 9'sd180) &&
                    (pitch_degrees >= -9'sd180) && (pitch_degrees <= 9'sd180);

  // A stalled result beat stays put.
  `DTAA_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_beat), "stalled beat changed")

  // Only one sample is in flight: taking a sample closes the input.
  `DTAA_ASSERT_NEXT(a_one_in_flight, in_take, in_stall, "second sample taken while busy")

  // No result can appear right after a sample is taken.
  `DTAA_ASSERT_NEXT(a_no_early_result, in_take, !$rose(out_valid), "result appeared too early")

  // Averaged angles stay within a half turn.
  `DTAA_ASSERT_SAME(a_angle_range, out_valid, in_range, "angle out of range")

endmodule

bind dual_tilt_angle_averager dtaa_checker u_dtaa_checker (.*);

@@ tb/sv/tilt_average_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the tilt averager, predicts each result beat from
// the accepted sample beats and compares the two angle fields in order.
module tilt_average_checker import dtaa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [IN_W-1:0]  accel_x,
  input  logic signed [IN_W-1:0]  accel_y,
  input  logic signed [IN_W-1:0]  accel_z,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [ANG_W-1:0] roll_degrees,
  input  logic signed [ANG_W-1:0] pitch_degrees,
  output int                      fail_count,
  output int                      outstanding
);

  typedef struct {
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] pitch;
  } angle_pair_t;

  // atan(2^-i) in degrees, 16 fraction bits.
  localparam longint ATAN_Q16 [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  logic signed [ANG_W-1:0] roll_hist  [WINDOW];
  logic signed [ANG_W-1:0] pitch_hist [WINDOW];
  logic [SLOT_W-1:0]       next_slot;
  logic                    window_primed;
  angle_pair_t             expected_angles [$];
  angle_pair_t             oldest;

  // atan2(num, den) in whole degrees by a vectoring CORDIC, truncated toward zero.
  function automatic logic signed [ANG_W-1:0] tilt_angle(input int num, input int den);
    longint vx, vy, acc, sx, sy, swap;
    int     mag_n, mag_d, deg, i;
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    if (num == 0) return (den < 0) ? ANG_P180 : ANG_ZERO;
    if (den == 0) return (num > 0) ? ANG_P90 : ANG_M90;
    if (mag_n == mag_d) begin
      if (den > 0) return (num > 0) ? ANG_P45 : ANG_M45;
      return (num > 0) ? ANG_P135 : ANG_M135;
    end

    // A vector in the left half plane is turned a quarter turn first.
    acc = 0;
    vx  = den;
    vy  = num;
    if (vx < 0) begin
      swap = vx;
      if (vy >= 0) begin
        vx  = vy;
        vy  = -swap;
        acc = longint'(90) <<< FRAC_BITS;
      end else begin
        vx  = -vy;
        vy  = swap;
        acc = longint'(-90) <<< FRAC_BITS;
      end
    end
    vx = vx * (longint'(1) <<< PRESCALE_SH);
    vy = vy * (longint'(1) <<< PRESCALE_SH);

    // Drive y toward zero, accumulating the rotation angle.
    for (i = 0; i < CORDIC_STEPS; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy > 0) begin
        vx  += sy;
        vy  -= sx;
        acc += ATAN_Q16[i];
      end else begin
        vx  -= sy;
        vy  += sx;
        acc -= ATAN_Q16[i];
      end
    end

    if (acc >= 0) deg = int'(acc >>> FRAC_BITS);
    else deg = -int'((-acc) >>> FRAC_BITS);
    if (deg > 180) deg = 180;
    if (deg < -180) deg = -180;
    return ANG_W'(deg);
  endfunction

  // Push one sample's angles into the windows and queue the averaged result.
  task automatic predict_sample(input logic signed [IN_W-1:0] ax,
                                input logic signed [IN_W-1:0] ay,
                                input logic signed [IN_W-1:0] az);
    logic signed [ANG_W-1:0] roll, pitch;
    angle_pair_t             avg;
    int                      rsum, psum, k;
    roll  = tilt_angle(ay, az);
    pitch = tilt_angle(ax, az);
    rsum  = 0;
    psum  = 0;
    if (!window_primed) begin
      for (k = 0; k < WINDOW; k++) begin
        roll_hist[k]  = roll;
        pitch_hist[k] = pitch;
      end
      window_primed = 1'b1;
    end
    roll_hist[next_slot]  = roll;
    pitch_hist[next_slot] = pitch;
    next_slot = (next_slot == SLOT_W'(WINDOW - 1)) ? '0 : next_slot + 1'b1;
    for (k = 0; k < WINDOW; k++) begin
      rsum += roll_hist[k];
      psum += pitch_hist[k];
    end
    avg.roll  = ANG_W'(rsum / WINDOW);
    avg.pitch = ANG_W'(psum / WINDOW);
    expected_angles.push_back(avg);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tilt check @%0t: %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Sample both channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) begin
        roll_hist[k]  = '0;
        pitch_hist[k] = '0;
      end
      next_slot     = '0;
      window_primed = 1'b0;
      expected_angles.delete();
      fail_count    = 0;
    end else begin
      if (in_valid && !in_stall) predict_sample(accel_x, accel_y, accel_z);
      if (out_valid && !out_stall) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("result beat with nothing pending", roll_degrees, 0);
        end else begin
          oldest = expected_angles.pop_front();
          if (roll_degrees !== oldest.roll)
            report_mismatch("roll_degrees", roll_degrees, oldest.roll);
          if (pitch_degrees !== oldest.pitch)
            report_mismatch("pitch_degrees", pitch_degrees, oldest.pitch);
        end
      end
    end
    outstanding = expected_angles.size();
  end

endmodule

@@ tb/sv/tb_dual_tilt_angle_averager.sv @@
`timescale 1ns / 100ps

module tb_dual_tilt_angle_averager;
  import dtaa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [IN_W-1:0]  accel_x = '0;
  logic signed [IN_W-1:0]  accel_y = '0;
  logic signed [IN_W-1:0]  accel_z = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [ANG_W-1:0] roll_degrees;
  logic signed [ANG_W-1:0] pitch_degrees;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dual_tilt_angle_averager i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .accel_x       (accel_x),
    .accel_y       (accel_y),
    .accel_z       (accel_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .roll_degrees  (roll_degrees),
    .pitch_degrees (pitch_degrees)
  );

  tilt_average_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .accel_x       (accel_x),
    .accel_y       (accel_y),
    .accel_z       (accel_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .roll_degrees  (roll_degrees),
    .pitch_degrees (pitch_degrees),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // Receiver back-pressure on the result channel.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one sample beat, with random idle cycles ahead of it.
  task automatic send_sample(input logic signed [IN_W-1:0] x,
                             input logic signed [IN_W-1:0] y,
                             input logic signed [IN_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x  <= x;
    accel_y  <= y;
    accel_z  <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off the sender until every pending result has come out.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Pick a field value from the boundary set.
  function automatic logic signed [IN_W-1:0] corner_value();
    case ($urandom_range(4))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3:       return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  // Random samples: mostly full-range vectors, plus small, axis-aligned,
  // equal-magnitude and boundary samples.
  task automatic send_random_samples(input int count);
    logic signed [IN_W-1:0] x, y, z;
    int                     kind, mag, n;
    for (n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      x = IN_W'($urandom());
      y = IN_W'($urandom());
      z = IN_W'($urandom());
      if (kind >= 60 && kind < 75) begin
        x = IN_W'(int'($urandom_range(40)) - 20);
        y = IN_W'(int'($urandom_range(40)) - 20);
        z = IN_W'(int'($urandom_range(40)) - 20);
      end else if (kind >= 75 && kind < 85) begin
        if ($urandom_range(1)) x = '0;
        if ($urandom_range(1)) y = '0;
        if ($urandom_range(1)) z = '0;
      end else if (kind >= 85 && kind < 93) begin
        mag = $urandom_range(32767, 1);
        x = IN_W'($urandom_range(1) ? mag : -mag);
        y = IN_W'($urandom_range(1) ? mag : -mag);
        z = IN_W'($urandom_range(1) ? mag : -mag);
      end else if (kind >= 93) begin
        x = corner_value();
        y = corner_value();
        z = corner_value();
      end
      send_sample(x, y, z);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender mostly busy, receiver stalls about half the time.
    send_idle_pct  = 6;
    recv_stall_pct = 52;

    // Directed samples: zero vector first, so it also fills the window.
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, -16'sd5);
    send_sample(16'sd0, 16'sd0, 16'sd5);
    send_sample(16'sd100, -16'sd100, 16'sd0);
    send_sample(-16'sd100, 16'sd100, 16'sd0);
    send_sample(16'sd300, 16'sd300, 16'sd300);
    send_sample(-16'sd300, -16'sd300, 16'sd300);
    send_sample(16'sd300, 16'sd300, -16'sd300);
    send_sample(-16'sd300, -16'sd300, -16'sd300);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(16'sd1, 16'sd1, 16'sh8000);
    send_sample(-16'sd1, -16'sd1, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff, 16'sd1);
    send_sample(16'sh7fff, 16'sh8000, -16'sd1);
    send_sample(16'sd1, -16'sd1, 16'sd2);
    send_sample(16'sd2, 16'sd1, -16'sd1);
    send_sample(16'sd0, 16'sd0, 16'sh8000);
    send_sample(16'sh8000, 16'sd0, 16'sd0);
    send_random_samples(380);
    wait_results_drained();

    // Sender idles about half the time, receiver rarely stalls.
    send_idle_pct  = 52;
    recv_stall_pct = 6;
    send_random_samples(380);

    // Full rate on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_samples(370);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
